/* design/ptw_pkg.sv */
// Shared types, constants and helpers for the four-level page table walker.
package ptw_pkg;

	localparam int VA_W     = 48;
	localparam int VPN_W    = 36;
	localparam int DATA_W   = 64;
	localparam int FRAME_W  = 40;
	localparam int PADDR_W  = 52;
	localparam int LEVEL_W  = 3;
	localparam int IDX_W    = 9;
	localparam int PAGE_W   = 12;
	localparam int S_DATA_W = 112;
	localparam int M_DATA_W = 120;

	localparam int QDEPTH   = 4;
	localparam int QPTR_W   = $clog2(QDEPTH);
	localparam int QCNT_W   = $clog2(QDEPTH + 1);

	localparam logic OP_TRANSLATE = 1'b0;
	localparam logic OP_RESPONSE  = 1'b1;

	localparam logic KIND_READ = 1'b0;
	localparam logic KIND_DONE = 1'b1;

	localparam logic [LEVEL_W-1:0] LEVEL_1 = 3'd1;
	localparam logic [LEVEL_W-1:0] LEVEL_2 = 3'd2;
	localparam logic [LEVEL_W-1:0] LEVEL_3 = 3'd3;
	localparam logic [LEVEL_W-1:0] LEVEL_4 = 3'd4;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_LARGE   = 7;

	typedef struct packed {
		logic              op;
		logic [VPN_W-1:0]  vpn;
		logic [DATA_W-1:0] data;
	} q_item_t;

	typedef struct packed {
		logic               kind;
		logic [PADDR_W-1:0] read_address;
		logic [DATA_W-1:0]  entry;
		logic [LEVEL_W-1:0] level;
	} result_t;

	function automatic logic [IDX_W-1:0] table_index(input logic [VPN_W-1:0] vpn,
		input logic [LEVEL_W-1:0] lvl);
		logic [IDX_W-1:0] idx;
		unique case (lvl)
			LEVEL_4: idx = vpn[35:27];
			LEVEL_3: idx = vpn[26:18];
			LEVEL_2: idx = vpn[17:9];
			default: idx = vpn[8:0];
		endcase
		return idx;
	endfunction

	function automatic logic [PADDR_W-1:0] entry_address(input logic [FRAME_W-1:0] frame,
		input logic [VPN_W-1:0] vpn, input logic [LEVEL_W-1:0] lvl);
		return {frame, table_index(vpn, lvl), 3'b000};
	endfunction

endpackage

/* design/ptw_front.sv */
// Front end: accepts stream transactions, turns each into a walk item and queues it.
module ptw_front
	import ptw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic                s_tuser,
	output logic                q_valid,
	output q_item_t             q_item,
	input  logic                q_pop
);

	q_item_t             fifo_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                push;
	logic                pop;
	q_item_t             item_in;

	always_comb begin
		item_in.op   = s_tuser;
		item_in.vpn  = s_tdata[VA_W-1:PAGE_W];
		item_in.data = s_tdata[VA_W+DATA_W-1:VA_W];
	end

	assign s_tready = (count_q != QCNT_W'(QDEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign pop      = q_pop && q_valid;
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count exceeds depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 && count_q != QCNT_W'(QDEPTH)) |-> (wr_ptr_q != rd_ptr_q))
		else $error("queue pointers disagree with count");

	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - QCNT_W'(1)))
		else $error("pop did not lower the count");

endmodule

/* design/ptw_back.sv */
// Back end: walk state, entry checks and the registered result stage.
module ptw_back
	import ptw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [FRAME_W-1:0] root_frame,
	input  logic               q_valid,
	input  q_item_t            q_item,
	output logic               q_pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output result_t            m_result
);

	logic               busy_q;
	logic [LEVEL_W-1:0] level_q;
	logic [VPN_W-1:0]   vpn_q;
	logic [FRAME_W-1:0] base_q;
	logic               out_valid_q;
	result_t            out_q;

	logic               out_free;
	logic               res_valid;
	result_t            res;
	logic               nxt_busy;
	logic [LEVEL_W-1:0] nxt_level;
	logic [VPN_W-1:0]   nxt_vpn;
	logic [FRAME_W-1:0] nxt_base;
	logic               present;
	logic               large_page;

	assign out_free   = !out_valid_q || m_tready;
	assign q_pop      = q_valid && out_free;
	assign present    = q_item.data[BIT_PRESENT];
	assign large_page = q_item.data[BIT_LARGE];

	always_comb begin
		res_valid        = 1'b0;
		res.kind         = KIND_READ;
		res.read_address = '0;
		res.entry        = '0;
		res.level        = level_q;
		nxt_busy         = busy_q;
		nxt_level        = level_q;
		nxt_vpn          = vpn_q;
		nxt_base         = base_q;
		if (q_item.op == OP_TRANSLATE) begin
			if (!busy_q) begin
				res_valid        = 1'b1;
				nxt_busy         = 1'b1;
				nxt_level        = LEVEL_4;
				nxt_vpn          = q_item.vpn;
				nxt_base         = root_frame;
				res.read_address = entry_address(root_frame, q_item.vpn, LEVEL_4);
				res.level        = LEVEL_4;
			end
		end else if (busy_q) begin
			res_valid = 1'b1;
			if (level_q <= LEVEL_1) begin
				res.kind  = KIND_DONE;
				res.entry = q_item.data;
				res.level = LEVEL_1;
				nxt_busy  = 1'b0;
			end else if (!present) begin
				res.kind  = KIND_DONE;
				nxt_busy  = 1'b0;
			end else if (large_page && (level_q == LEVEL_3 || level_q == LEVEL_2)) begin
				res.kind  = KIND_DONE;
				res.entry = q_item.data;
				nxt_busy  = 1'b0;
			end else begin
				nxt_base         = q_item.data[PADDR_W-1:PAGE_W];
				nxt_level        = level_q - LEVEL_W'(1);
				res.level        = nxt_level;
				res.read_address = entry_address(nxt_base, vpn_q, nxt_level);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= LEVEL_4;
			vpn_q       <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q  <= nxt_busy;
				level_q <= nxt_level;
				vpn_q   <= nxt_vpn;
				base_q  <= nxt_base;
			end
			if (out_free) begin
				out_valid_q <= q_pop && res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_result = out_q;

	a_done_idles: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && res_valid && res.kind == KIND_DONE) |=> !busy_q)
		else $error("finished walk left the walker busy");

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && res_valid && res.kind == KIND_READ) |=>
		(busy_q && level_q == $past(res.level)))
		else $error("read request does not match walk level");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (level_q >= LEVEL_1 && level_q <= LEVEL_4))
		else $error("walk level out of range");

	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && !res_valid) |=> !out_valid_q)
		else $error("ignored item produced a result");

endmodule

/* design/page_table_walker_four_level.sv */
// Top level of the four-level page table walker.
// Usage: items arrive on the s_ stream; tuser 0 is a translate request (virtual
// address in tdata), tuser 1 is a memory response (64-bit entry in tdata). Each
// accepted item that is not ignored gives one transaction on the m_ stream:
// tuser 0 asks for an 8-byte entry read at the address in tdata, tuser 1 ends
// the walk with the final entry (zero when not present) and the level.
// A request while a walk is running and a response while idle give nothing.
// The root table frame is written through cfg_wen and cfg_wdata; the user must write
// it only while idle, as the block does not enforce this. Items pass through the input
// queue and then the output register. One transaction per cycle is sustained while the
// receiver does not stall; the walk state updates once per item in the back end.
// When the receiver stalls, the output register holds its result, the back end
// stops draining, and the four-entry input queue fills before s_tready drops.
// Reset clears the queue, the output register and the walk state; the root
// frame resets to zero. There is no clearing pass after reset.
module page_table_walker_four_level
	import ptw_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wen,
	input  logic [FRAME_W-1:0]  cfg_wdata,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // virtual_address, read_data
	input  logic                s_tuser,  // op
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // read_address, entry, level, zero pad
	output logic                m_tuser   // kind
);

	logic [FRAME_W-1:0] root_frame_q;
	logic               q_valid;
	logic               q_pop;
	q_item_t            q_item;
	result_t            m_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_frame_q <= '0;
		end else if (cfg_wen) begin
			root_frame_q <= cfg_wdata;
		end
	end

	ptw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ptw_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.root_frame (root_frame_q),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_result   (m_result)
	);

	assign m_tdata = {1'b0, m_result.level, m_result.entry, m_result.read_address};
	assign m_tuser = m_result.kind;

endmodule

/* dv/tb_page_table_walker_four_level.sv */
// Testbench for the four-level page table walker: directed and random walks checked per transaction.
module tb_page_table_walker_four_level
	import ptw_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int WALK_ITEMS_PER_PHASE = 325;

	typedef struct {
		logic               kind;
		logic [PADDR_W-1:0] read_address;
		logic [DATA_W-1:0]  entry;
		logic [LEVEL_W-1:0] level;
	} walk_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wen = 1'b0;
	logic [FRAME_W-1:0]  cfg_wdata = '0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic                s_tuser = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic                m_tuser;

	logic               walking = 1'b0;
	logic [LEVEL_W-1:0] cur_level = LEVEL_4;
	logic [VPN_W-1:0]   vpn_latched = '0;
	logic [PADDR_W-1:0] next_table_addr = '0;
	logic [FRAME_W-1:0] root_frame = '0;

	walk_result_t expected_walk_results[$];
	int unsigned mismatches = 0;
	int unsigned walk_items = 0;
	int unsigned burst_left = 0;
	bit          sender_gaps = 1'b1;
	int unsigned ready_hold = 0;
	int unsigned idle_cycles = 0;

	page_table_walker_four_level dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #10 clk = ~clk;

	function automatic walk_result_t entry_read();
		walk_result_t r;
		logic [IDX_W-1:0] idx;
		case (cur_level)
			LEVEL_4: idx = vpn_latched[35:27];
			LEVEL_3: idx = vpn_latched[26:18];
			LEVEL_2: idx = vpn_latched[17:9];
			default: idx = vpn_latched[8:0];
		endcase
		r.kind = KIND_READ;
		r.read_address = next_table_addr + PADDR_W'({idx, 3'b000});
		r.entry = '0;
		r.level = cur_level;
		return r;
	endfunction

	function automatic walk_result_t walk_done(input logic [DATA_W-1:0] e,
		input logic [LEVEL_W-1:0] lvl);
		walk_result_t r;
		walking = 1'b0;
		r.kind = KIND_DONE;
		r.read_address = '0;
		r.entry = e;
		r.level = lvl;
		return r;
	endfunction

	// Returns 1 when the transaction produces a result, which is placed in r.
	function automatic bit walk_step(input logic op, input logic [VA_W-1:0] va,
		input logic [DATA_W-1:0] rd, output walk_result_t r);
		if (op == OP_TRANSLATE) begin
			if (walking)
				return 1'b0;
			walking = 1'b1;
			cur_level = LEVEL_4;
			vpn_latched = va[VA_W-1:PAGE_W];
			next_table_addr = {root_frame, {PAGE_W{1'b0}}};
			r = entry_read();
			return 1'b1;
		end
		if (!walking)
			return 1'b0;
		if (cur_level <= LEVEL_1) begin
			r = walk_done(rd, LEVEL_1);
		end else if (!rd[BIT_PRESENT]) begin
			r = walk_done('0, cur_level);
		end else if ((cur_level == LEVEL_3 || cur_level == LEVEL_2) && rd[BIT_LARGE]) begin
			r = walk_done(rd, cur_level);
		end else begin
			next_table_addr = {rd[PADDR_W-1:PAGE_W], {PAGE_W{1'b0}}};
			cur_level = cur_level - LEVEL_W'(1);
			r = entry_read();
		end
		return 1'b1;
	endfunction

	function automatic logic [DATA_W-1:0] rand_entry();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [VA_W-1:0] rand_va();
		logic [63:0] v;
		v = {$urandom, $urandom};
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 5))
				0: v[PAGE_W + IDX_W * k +: IDX_W] = '0;
				1: v[PAGE_W + IDX_W * k +: IDX_W] = '1;
				default: ;
			endcase
		end
		return v[VA_W-1:0];
	endfunction

	task automatic send_item(input logic op, input logic [VA_W-1:0] va,
		input logic [DATA_W-1:0] rd);
		walk_result_t r;
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = sender_gaps ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {rd, va};
		do @(posedge clk); while (!s_tready);
		if (walk_step(op, va, rd, r)) begin
			expected_walk_results.push_back(r);
			walk_items++;
		end
	endtask

	task automatic wait_results_drained();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (expected_walk_results.size() != 0);
	endtask

	task automatic set_root_frame(input logic [FRAME_W-1:0] frame);
		logic [DATA_W-1:0] e;
		while (walking) begin
			e = rand_entry();
			e[BIT_PRESENT] = 1'b0;
			send_item(OP_RESPONSE, rand_va(), e);
		end
		wait_results_drained();
		repeat (4) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= frame;
		@(posedge clk);
		cfg_wen <= 1'b0;
		root_frame = frame;
	endtask

	task automatic test_walk_endings();
		send_item(OP_RESPONSE, rand_va(), 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_TRANSLATE, 48'hFFFF_FFFF_FFFF, rand_entry());
		send_item(OP_TRANSLATE, 48'h0000_0000_0000, rand_entry());
		// The large-page bit has no effect at the top level.
		send_item(OP_RESPONSE, rand_va(), 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_RESPONSE, rand_va(), 64'h7FF0_1234_5678_9001);
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_0001);
		send_item(OP_RESPONSE, rand_va(), 64'hFFFF_FFFF_FFFF_FFFE);
		set_root_frame(40'hFF_FFFF_FFFF);
		send_item(OP_TRANSLATE, 48'h0000_0000_0000, rand_entry());
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_0000);
		send_item(OP_TRANSLATE, 48'h8000_4020_1000, rand_entry());
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0001_2345_6001);
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_4000_0081);
		send_item(OP_TRANSLATE, 48'h0000_8040_0000, rand_entry());
		send_item(OP_RESPONSE, rand_va(), 64'h000F_FFFF_FFFF_F001);
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_1001);
		send_item(OP_RESPONSE, rand_va(), 64'hFFFF_FFFF_FFFF_FFFF);
		send_item(OP_TRANSLATE, rand_va(), rand_entry());
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_2001);
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_3001);
		send_item(OP_RESPONSE, rand_va(), 64'hFFFF_FFFF_FFFF_FFFE);
		send_item(OP_TRANSLATE, rand_va(), rand_entry());
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_4001);
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_5001);
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_6001);
		send_item(OP_RESPONSE, rand_va(), 64'h0000_0000_0000_0081);
	endtask

	task automatic test_random_walks(input logic [FRAME_W-1:0] frame, input bit gaps);
		int unsigned target;
		logic [DATA_W-1:0] e;
		set_root_frame(frame);
		sender_gaps = gaps;
		target = walk_items + WALK_ITEMS_PER_PHASE;
		while (walk_items < target) begin
			if ($urandom_range(0, 99) < 4)
				send_item(OP_RESPONSE, rand_va(), rand_entry());
			if ($urandom_range(0, 99) == 0)
				wait_results_drained();
			send_item(OP_TRANSLATE, rand_va(), rand_entry());
			while (walking) begin
				if ($urandom_range(0, 99) < 4)
					send_item(OP_TRANSLATE, rand_va(), rand_entry());
				e = rand_entry();
				e[BIT_PRESENT] = $urandom_range(0, 99) < 85;
				e[BIT_LARGE] = $urandom_range(0, 99) < 30;
				send_item(OP_RESPONSE, rand_va(), e);
			end
		end
	endtask

	function automatic void compare_field(input string name, input logic [DATA_W-1:0] want,
		input logic [DATA_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		walk_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_walk_results.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual kind %0d data %h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				want = expected_walk_results.pop_front();
				compare_field("kind", DATA_W'(want.kind), DATA_W'(m_tuser));
				compare_field("read_address", DATA_W'(want.read_address),
					DATA_W'(m_tdata[PADDR_W-1:0]));
				compare_field("entry", want.entry, m_tdata[PADDR_W +: DATA_W]);
				compare_field("level", DATA_W'(want.level),
					DATA_W'(m_tdata[PADDR_W + DATA_W +: LEVEL_W]));
			end
		end
	end

	always @(posedge clk) begin
		if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					m_tready <= 1'b1;
					ready_hold <= $urandom_range(0, 40);
				end
				1: begin
					m_tready <= 1'b0;
					ready_hold <= $urandom_range(0, 12);
				end
				default: begin
					m_tready <= 1'($urandom_range(0, 1));
					ready_hold <= 0;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("[page_table_walker_four_level] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_walk_endings();
		test_random_walks(40'h00_0000_0000, 1'b1);
		test_random_walks(40'hFF_FFFF_FFFF, 1'b0);
		test_random_walks(FRAME_W'({$urandom, $urandom}), 1'b1);
		test_random_walks(FRAME_W'({$urandom, $urandom}), 1'b1);
		test_random_walks(FRAME_W'({$urandom, $urandom}), 1'b0);
		wait_results_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("[page_table_walker_four_level] OK");
		end else begin
			$display("[page_table_walker_four_level] ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
design/ptw_pkg.sv
design/ptw_front.sv
design/ptw_back.sv
design/page_table_walker_four_level.sv
dv/tb_page_table_walker_four_level.sv
